FILE: rtl/vblfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vblfp_pkg
// Shared types and constants of the first labeling pass: item layouts,
// result kinds, register map and parameter defaults.
// ----------------------------------------------------------------------------
package vblfp_pkg;

  // field widths of the input and result items
  localparam int LABEL_W  = 20;
  localparam int COLUMN_W = 10;
  localparam int ROW_W    = 10;
  localparam int FRAME_W  = 16;
  localparam int SAMPLE_W = 32;
  localparam int COUNT_W  = 32;

  localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};

  // parameter defaults
  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_LABEL_BITS  = 20;

  // configuration port
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int SIZE_W  = 11;
  localparam int INDEX_W = ADDR_W - 2;

  localparam logic [INDEX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [INDEX_W-1:0] REG_COLUMNS   = 2'd1;
  localparam logic [INDEX_W-1:0] REG_ROWS      = 2'd2;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 32'd196608;
  localparam logic [SIZE_W-1:0]   COLUMNS_RESET   = 11'd1024;
  localparam logic [SIZE_W-1:0]   ROWS_RESET      = 11'd1024;

  // result kinds
  localparam logic [1:0] KIND_NEW  = 2'd0;
  localparam logic [1:0] KIND_OLD  = 2'd1;
  localparam logic [1:0] KIND_PAIR = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered_sample;
    logic [COUNT_W-1:0]         raw_count;
    logic                       start_of_volume;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [LABEL_W-1:0]  first_label;
    logic [LABEL_W-1:0]  second_label;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic [FRAME_W-1:0]  frame;
    logic [COUNT_W-1:0]  pixel_count;
    logic                last;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/volume_blob_label_first_pass_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// volume_blob_label_first_pass_core
// First pass of 3D connected-component labeling over a raster pixel stream.
// ----------------------------------------------------------------------------
// One pixel is taken per clock while in_stall is low; the next pixel waits
// until the last result of the current one leaves. A foreground pixel gives
// one result per equivalence pair it raises, then its pixel result, through
// the label stage registers and the output register; a background pixel
// gives none. Results leave one per clock while out_stall is low. The label
// store is one synchronous memory of MAX_ROWS x MAX_COLUMNS labels (rows and
// columns rounded up to powers of two), read at the upper and previous-frame
// neighbor when a pixel is taken and written when the pixel retires; a
// write that meets a read of the same entry is forwarded. The store needs
// no clearing after reset: row 0 and frame 0 of a volume never use it.
// ----------------------------------------------------------------------------
module volume_blob_label_first_pass_core #(
  parameter int MAX_COLUMNS = vblfp_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = vblfp_pkg::DEF_MAX_ROWS,
  parameter int LABEL_BITS  = vblfp_pkg::DEF_LABEL_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire vblfp_pkg::in_item_t           in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output vblfp_pkg::out_item_t               out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [vblfp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [vblfp_pkg::DATA_W-1:0]  pwdata,
  output logic      [vblfp_pkg::DATA_W-1:0]  prdata,
  output logic                               pready
);

  localparam int CB    = $clog2(MAX_COLUMNS);
  localparam int RB    = $clog2(MAX_ROWS);
  localparam int CNW   = $clog2(MAX_COLUMNS + 1);
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int AW    = RB + CB;
  localparam int DEPTH = 1 << AW;
  localparam int LB    = LABEL_BITS;
  localparam int LW    = vblfp_pkg::LABEL_W;
  localparam int CW    = vblfp_pkg::COLUMN_W;
  localparam int RW    = vblfp_pkg::ROW_W;
  localparam int FW    = vblfp_pkg::FRAME_W;
  localparam int SW    = vblfp_pkg::SIZE_W;
  localparam int DW    = vblfp_pkg::DATA_W;
  localparam int IW    = vblfp_pkg::INDEX_W;
  localparam logic [LB-1:0] LABEL_MAX = {LB{1'b1}};

  typedef struct packed {
    logic [LB-1:0] hi;
    logic [LB-1:0] lo;
  } pair_t;

  function automatic pair_t order_pair(input logic [LB-1:0] a, input logic [LB-1:0] b);
    pair_t p;
    if (a < b) begin
      p.hi = b;
      p.lo = a;
    end else begin
      p.hi = a;
      p.lo = b;
    end
    return p;
  endfunction

  // configuration registers
  logic [DW-1:0] threshold_r;
  logic [SW-1:0] columns_r;
  logic [SW-1:0] rows_r;
  logic [IW-1:0] reg_index;
  logic          cfg_write;
  logic [CNW-1:0] cols_c;
  logic [RNW-1:0] rows_c;

  assign pready    = 1'b1;
  assign reg_index = paddr[vblfp_pkg::ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= vblfp_pkg::THRESHOLD_RESET;
      columns_r   <= vblfp_pkg::COLUMNS_RESET;
      rows_r      <= vblfp_pkg::ROWS_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        vblfp_pkg::REG_THRESHOLD: threshold_r <= pwdata;
        vblfp_pkg::REG_COLUMNS:   columns_r   <= pwdata[SW-1:0];
        vblfp_pkg::REG_ROWS:      rows_r      <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      vblfp_pkg::REG_THRESHOLD: prdata = threshold_r;
      vblfp_pkg::REG_COLUMNS:   prdata = DW'(columns_r);
      vblfp_pkg::REG_ROWS:      prdata = DW'(rows_r);
      default:                  prdata = '0;
    endcase
  end

  // size clamping
  always_comb begin
    if (columns_r == '0) begin
      cols_c = CNW'(1);
    end else if (32'(columns_r) > MAX_COLUMNS) begin
      cols_c = CNW'(MAX_COLUMNS);
    end else begin
      cols_c = CNW'(columns_r);
    end
    if (rows_r == '0) begin
      rows_c = RNW'(1);
    end else if (32'(rows_r) > MAX_ROWS) begin
      rows_c = RNW'(MAX_ROWS);
    end else begin
      rows_c = RNW'(rows_r);
    end
  end

  // intake stage
  logic          in_accept;
  logic [CB-1:0] pix_col;
  logic [RB-1:0] pix_row;
  logic [FW-1:0] pix_frame;
  logic [RB-1:0] top_row;
  logic [AW-1:0] pix_addr;
  logic [AW-1:0] top_addr;
  logic          below;

  assign in_accept = in_valid && !in_stall;

  vblfp_raster_pos #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_raster_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_accept),
    .sov       (in_data.start_of_volume),
    .cols      (cols_c),
    .rows      (rows_c),
    .pix_col   (pix_col),
    .pix_row   (pix_row),
    .pix_frame (pix_frame)
  );

  assign top_row  = pix_row - RB'(1);
  assign pix_addr = {pix_row, pix_col};
  assign top_addr = {top_row, pix_col};
  assign below    = $signed(in_data.filtered_sample) < $signed(threshold_r);

  // label stage registers
  logic          s1_valid_r;
  logic          s1_bg_r;
  logic          s1_sov_r;
  logic [CB-1:0] s1_col_r;
  logic [RB-1:0] s1_row_r;
  logic [FW-1:0] s1_frame_r;
  logic [vblfp_pkg::COUNT_W-1:0] s1_raw_r;
  logic [AW-1:0] s1_addr_r;
  logic [LB-1:0] top_rd_r;
  logic [LB-1:0] prev_rd_r;
  logic          fwd_top_r;
  logic          fwd_prev_r;
  logic [LB-1:0] fwd_label_r;
  logic [LB-1:0] left_label_r;
  logic [LB-1:0] counter_r, counter_nxt;
  logic [1:0]    idx_r;

  logic [LB-1:0] label_mem [0:DEPTH-1];

  // label decision
  logic [LB-1:0] top_v, prev_v, left, top, prev, cnt_eff, label, wr_label;
  logic [1:0]    kind;
  logic [1:0]    n_pairs;
  pair_t         pairs [0:2];
  logic [2:0]    code;
  logic          s1_retire;
  logic          emit_ok;
  logic          emit;
  logic          final_result;
  vblfp_pkg::out_item_t cur_item;
  pair_t         cur_pair;

  always_comb begin
    top_v   = fwd_top_r ? fwd_label_r : top_rd_r;
    prev_v  = fwd_prev_r ? fwd_label_r : prev_rd_r;
    left    = (s1_col_r == '0) ? '0 : left_label_r;
    top     = (s1_row_r == '0) ? '0 : top_v;
    prev    = (s1_frame_r == '0) ? '0 : prev_v;
    cnt_eff = s1_sov_r ? '0 : counter_r;
    code    = {prev != '0, top != '0, left != '0};

    counter_nxt = cnt_eff;
    kind        = vblfp_pkg::KIND_OLD;
    n_pairs     = 2'd0;
    pairs[0]    = order_pair(top, prev);
    pairs[1]    = order_pair(top, left);
    pairs[2]    = order_pair(left, prev);
    label       = left;

    unique case (code)
      3'b000: begin
        if (cnt_eff != LABEL_MAX) begin
          counter_nxt = cnt_eff + LB'(1);
          kind        = vblfp_pkg::KIND_NEW;
        end
        label = counter_nxt;
      end
      3'b001: label = left;
      3'b010: label = top;
      3'b011: begin
        label = top;
        if (top != left) begin
          pairs[0] = order_pair(top, left);
          n_pairs  = 2'd1;
        end
      end
      3'b100: label = prev;
      3'b101: begin
        label = left;
        if (left != prev) begin
          pairs[0] = order_pair(left, prev);
          n_pairs  = 2'd1;
        end
      end
      3'b110: begin
        label = top;
        if (top != prev) begin
          pairs[0] = order_pair(top, prev);
          n_pairs  = 2'd1;
        end
      end
      3'b111: begin
        label = left;
        priority if (top == left && top != prev) begin
          pairs[0] = order_pair(top, prev);
          n_pairs  = 2'd1;
        end else if (top == prev && top != left) begin
          pairs[0] = order_pair(top, left);
          n_pairs  = 2'd1;
        end else if (left == prev && left != top) begin
          pairs[0] = order_pair(left, top);
          n_pairs  = 2'd1;
        end else if (left != prev && left != top && top != prev) begin
          n_pairs = 2'd3;
        end else begin
          n_pairs = 2'd0;
        end
      end
      default: label = left;
    endcase

    wr_label = s1_bg_r ? '0 : label;
  end

  // result selection
  always_comb begin
    final_result = (idx_r == n_pairs);
    cur_pair     = pairs[final_result ? 2'd0 : idx_r];
    cur_item.column      = CW'(s1_col_r);
    cur_item.row         = RW'(s1_row_r);
    cur_item.frame       = s1_frame_r;
    cur_item.pixel_count = s1_raw_r;
    if (final_result) begin
      cur_item.kind         = kind;
      cur_item.first_label  = LW'(label);
      cur_item.second_label = '0;
      cur_item.last         = 1'b1;
    end else begin
      cur_item.kind         = vblfp_pkg::KIND_PAIR;
      cur_item.first_label  = LW'(cur_pair.hi);
      cur_item.second_label = LW'(cur_pair.lo);
      cur_item.last         = 1'b0;
    end
  end

  assign emit_ok   = !out_valid || !out_stall;
  assign emit      = s1_valid_r && !s1_bg_r && emit_ok;
  assign s1_retire = s1_valid_r && (s1_bg_r || (emit_ok && final_result));
  assign in_stall  = s1_valid_r && !s1_retire;

  // label store: neighbor reads on transfer, write on retire
  always_ff @(posedge clk) begin
    if (in_accept) begin
      top_rd_r  <= label_mem[top_addr];
      prev_rd_r <= label_mem[pix_addr];
    end
    if (s1_retire) begin
      label_mem[s1_addr_r] <= wr_label;
    end
  end

  // label stage payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_bg_r     <= below;
      s1_sov_r    <= in_data.start_of_volume;
      s1_col_r    <= pix_col;
      s1_row_r    <= pix_row;
      s1_frame_r  <= pix_frame;
      s1_raw_r    <= in_data.raw_count;
      s1_addr_r   <= pix_addr;
      fwd_top_r   <= s1_retire && (top_addr == s1_addr_r);
      fwd_prev_r  <= s1_retire && (pix_addr == s1_addr_r);
      fwd_label_r <= wr_label;
    end
    if (emit) begin
      out_data <= cur_item;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      idx_r        <= '0;
      left_label_r <= '0;
      counter_r    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_retire) begin
        s1_valid_r <= 1'b0;
      end
      if (emit) begin
        idx_r <= final_result ? '0 : idx_r + 2'd1;
      end
      if (s1_retire) begin
        left_label_r <= wr_label;
        counter_r    <= s1_bg_r ? cnt_eff : counter_nxt;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vblfp_raster_pos.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vblfp_raster_pos
// Raster position tracker: gives the column, row and frame of the pixel
// offered now, wrapping positions beyond the frame size, and steps on each
// accepted pixel.
// ----------------------------------------------------------------------------
module vblfp_raster_pos #(
  parameter int MAX_COLUMNS = vblfp_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = vblfp_pkg::DEF_MAX_ROWS,
  localparam int CB  = $clog2(MAX_COLUMNS),
  localparam int RB  = $clog2(MAX_ROWS),
  localparam int CNW = $clog2(MAX_COLUMNS + 1),
  localparam int RNW = $clog2(MAX_ROWS + 1),
  localparam int FW  = vblfp_pkg::FRAME_W
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire logic           sov,
  input  wire logic [CNW-1:0] cols,
  input  wire logic [RNW-1:0] rows,
  output logic      [CB-1:0]  pix_col,
  output logic      [RB-1:0]  pix_row,
  output logic      [FW-1:0]  pix_frame
);

  logic [CB-1:0]  col_r, col_nxt;
  logic [RB-1:0]  row_r, row_nxt;
  logic [FW-1:0]  frame_r, frame_nxt;
  logic [CNW-1:0] c_cur, c_next;
  logic [RNW-1:0] r_cur, r_next;
  logic [FW-1:0]  f_cur, f_next;

  always_comb begin
    c_cur = sov ? '0 : CNW'(col_r);
    r_cur = sov ? '0 : RNW'(row_r);
    f_cur = sov ? '0 : frame_r;
    // sizes shrunk mid-frame
    if (c_cur >= cols) begin
      c_cur = '0;
      r_cur = r_cur + RNW'(1);
    end
    if (r_cur >= rows) begin
      r_cur = '0;
      if (f_cur != vblfp_pkg::FRAME_MAX) begin
        f_cur = f_cur + FW'(1);
      end
    end
    pix_col   = CB'(c_cur);
    pix_row   = RB'(r_cur);
    pix_frame = f_cur;

    // advance past this pixel
    c_next = c_cur + CNW'(1);
    r_next = r_cur;
    f_next = f_cur;
    if (c_next >= cols) begin
      c_next = '0;
      r_next = r_cur + RNW'(1);
      if (r_next >= rows) begin
        r_next = '0;
        if (f_next != vblfp_pkg::FRAME_MAX) begin
          f_next = f_next + FW'(1);
        end
      end
    end
    col_nxt   = CB'(c_next);
    row_nxt   = RB'(r_next);
    frame_nxt = f_next;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      frame_r <= '0;
    end else if (step) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      frame_r <= frame_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vblfp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vblfp_checker
// Port-level checks of the labeling pass result channel, bound to the top.
// ----------------------------------------------------------------------------
module vblfp_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire vblfp_pkg::out_item_t out_data
);

  // nothing pending right after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // only the pixel result closes a run
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.kind != vblfp_pkg::KIND_PAIR)))
    else $error("last flag disagrees with kind");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.second_label == '0)
    else $error("pixel result with second label");

  // a pair transfer is followed at once by a result of the same pixel
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.kind == vblfp_pkg::KIND_PAIR
    |=> out_valid && $stable(out_data.column) && $stable(out_data.row)
        && $stable(out_data.frame))
    else $error("pair not followed by its pixel");

endmodule

bind volume_blob_label_first_pass_core vblfp_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
